@@ rtl/core/mcbb_pkg.sv @@
// Shared types and constants for the motor cruise bang-bang speed controller.
// Used by the controller, the datapath and the top level; no dependencies.
package mcbb_pkg;

  // Field widths.
  localparam int CAPTURE_BITS = 16;
  localparam int DUTY_BITS    = 12;
  localparam int RPM_BITS     = 24;
  localparam int DB_BITS      = 16;
  localparam int CFG_IDX_BITS = 2;

  // The divider produces one quotient bit per cycle.
  localparam int DIV_STEPS    = RPM_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};
  localparam logic [RPM_BITS-1:0]  RPM_MAX  = {RPM_BITS{1'b1}};

  // Register reset values.
  localparam logic [DB_BITS-1:0]   DEADBAND_RST  = DB_BITS'(100);
  localparam logic [DUTY_BITS-1:0] DUTY_STEP_RST = DUTY_BITS'(5);
  localparam logic [RPM_BITS-1:0]  RPM_SCALE_RST = RPM_BITS'(300000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_STEP = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RPM_SCALE = 2'd2;

  // Adjustment direction codes.
  localparam logic [1:0] DIR_HOLD = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // One measurement round.
  typedef struct packed {
    logic                    cruise_on;
    logic [DUTY_BITS-1:0]    adc_sample;
    logic [CAPTURE_BITS-1:0] capture_start;
    logic [CAPTURE_BITS-1:0] capture_end;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [DUTY_BITS-1:0] pwm_compare;
    logic [RPM_BITS-1:0]  measured_rpm;
    logic [1:0]           adjust_dir;
    logic [RPM_BITS-1:0]  setpoint_out;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_last;
  } dp_status_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

endpackage

@@ rtl/core/mcbb_ctrl.sv @@
// Sequencing state machine for the cruise controller: accept, divide, commit.
// Depends on mcbb_pkg; drives the datapath through dp_cmd_t.
module mcbb_ctrl
  import mcbb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The result register can take a new result when empty or being drained.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  // Command decode and next state.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd_o.step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A commit never overwrites a result that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit overwrote a pending result");

  // An accepted request starts the divider on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (cmd_o.step && !in_ready_o))
    else $error("divider did not start after accept");

  // Every commit leaves a valid result behind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("result not valid after commit");

endmodule

@@ rtl/core/mcbb_dp.sv @@
// Datapath of the cruise controller: config registers, bit-serial speed divider,
// regulation state and the result register. Depends on mcbb_pkg.
module mcbb_dp
  import mcbb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [RPM_BITS-1:0]     cfg_data_i,
  input  in_req_t                 in_req_i,
  input  dp_cmd_t                 cmd_i,
  output dp_status_t              status_o,
  output out_rsp_t                out_rsp_o
);

  // Configuration registers.
  logic [DB_BITS-1:0]   deadband_q;
  logic [DUTY_BITS-1:0] duty_step_q;
  logic [RPM_BITS-1:0]  rpm_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q  <= DEADBAND_RST;
      duty_step_q <= DUTY_STEP_RST;
      rpm_scale_q <= RPM_SCALE_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DEADBAND) begin
        deadband_q <= cfg_data_i[DB_BITS-1:0];
      end
      if (cfg_index_i == CFG_DUTY_STEP) begin
        duty_step_q <= cfg_data_i[DUTY_BITS-1:0];
      end
      if (cfg_index_i == CFG_RPM_SCALE) begin
        rpm_scale_q <= cfg_data_i;
      end
    end
  end

  // Latched request fields and divider registers.
  logic                    cruise_q;
  logic [DUTY_BITS-1:0]    adc_q;
  logic [CAPTURE_BITS-1:0] period_q;
  logic [RPM_BITS-1:0]     quo_q, quo_d;
  logic [CAPTURE_BITS-1:0] rem_q, rem_d;
  logic [DIV_CNT_BITS-1:0] cnt_q;

  logic [CAPTURE_BITS:0]   trial;
  logic [CAPTURE_BITS+1:0] diff;
  logic                    fits;

  // One restoring-division step: shift in the next dividend bit and subtract.
  always_comb begin
    trial = {rem_q, quo_q[RPM_BITS-1]};
    diff  = {1'b0, trial} - {2'b00, period_q};
    fits  = !diff[CAPTURE_BITS+1];
    rem_d = fits ? diff[CAPTURE_BITS-1:0] : trial[CAPTURE_BITS-1:0];
    quo_d = {quo_q[RPM_BITS-2:0], fits};
  end

  assign status_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cruise_q <= in_req_i.cruise_on;
      adc_q    <= in_req_i.adc_sample;
      period_q <= in_req_i.capture_end - in_req_i.capture_start;
      quo_q    <= rpm_scale_q;
      rem_q    <= '0;
      cnt_q    <= DIV_CNT_BITS'(DIV_STEPS - 1);
    end else if (cmd_i.step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q - DIV_CNT_BITS'(1);
    end
  end

  // Regulation state.
  logic                 first_q;
  logic [RPM_BITS-1:0]  setpoint_q, setpoint_d;
  logic [DUTY_BITS-1:0] duty_q, duty_d;
  logic [DUTY_BITS-1:0] pwm_q, pwm_d;
  logic [1:0]           dir_d;

  logic [RPM_BITS-1:0]  speed;
  logic [DUTY_BITS-1:0] duty_base;
  logic [DUTY_BITS:0]   duty_sum;
  logic [RPM_BITS:0]    speed_lo, band_hi;
  logic                 too_slow, too_fast;

  // Bang-bang decision with deadband and duty saturation.
  always_comb begin
    speed      = (period_q == '0) ? RPM_MAX : quo_q;
    duty_base  = (first_q || !cruise_q) ? adc_q : duty_q;
    duty_sum   = {1'b0, duty_base} + {1'b0, duty_step_q};
    speed_lo   = {1'b0, speed} + (RPM_BITS + 1)'(deadband_q);
    band_hi    = {1'b0, setpoint_q} + (RPM_BITS + 1)'(deadband_q);
    too_slow   = speed_lo < {1'b0, setpoint_q};
    too_fast   = {1'b0, speed} > band_hi;
    setpoint_d = setpoint_q;
    duty_d     = duty_base;
    pwm_d      = pwm_q;
    dir_d      = DIR_HOLD;
    priority if (!cruise_q) begin
      pwm_d      = duty_base;
      setpoint_d = speed;
    end else if (too_slow) begin
      duty_d = duty_sum[DUTY_BITS] ? DUTY_MAX : duty_sum[DUTY_BITS-1:0];
      pwm_d  = duty_d;
      dir_d  = DIR_UP;
    end else if (too_fast) begin
      duty_d = (duty_base > duty_step_q) ? (duty_base - duty_step_q) : '0;
      pwm_d  = duty_d;
      dir_d  = DIR_DOWN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b1;
      setpoint_q <= '0;
      duty_q     <= '0;
      pwm_q      <= '0;
    end else if (cmd_i.commit) begin
      first_q    <= 1'b0;
      setpoint_q <= setpoint_d;
      duty_q     <= duty_d;
      pwm_q      <= pwm_d;
    end
  end

  // Result register.
  out_rsp_t rsp_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_q.pwm_compare  <= pwm_d;
      rsp_q.measured_rpm <= speed;
      rsp_q.adjust_dir   <= dir_d;
      rsp_q.setpoint_out <= setpoint_d;
    end
  end

  assign out_rsp_o = rsp_q;

endmodule

@@ rtl/core/motor_cruise_bang_bang_control.sv @@
// Top level of the motor cruise bang-bang speed controller.
// Depends on mcbb_pkg, mcbb_ctrl and mcbb_dp.
//
// Each request is one measurement round; it produces exactly one result. A
// request goes from acceptance to a valid result in order: the accepting edge
// latches it, the bit-serial divider forms rpm_scale / period one quotient bit
// per cycle, and the commit step updates duty, PWM and setpoint. The next
// request is accepted in the cycle after the result is registered, so no new
// request is taken while one is in flight. The commit update waits while an older
// result still sits unread at the output, which stalls the input too.
// Configuration writes are always ready and take effect at once; write them
// only while no request is in flight.
module motor_cruise_bang_bang_control
  import mcbb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_req_t                 in_req_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_rsp_t                out_rsp_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [RPM_BITS-1:0]     cfg_data_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  mcbb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Divider, regulation state and result register.
  mcbb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
